/* src/hcsg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hcsg_pkg
// Shared types, constants and grammar table for the Hilbert curve step
// generator.
// ----------------------------------------------------------------------------
package hcsg_pkg;

	localparam int MAX_LEVEL = 8;
	localparam int RULE_LEN  = 11;
	localparam int DEPTH_W   = $clog2(MAX_LEVEL + 1);
	localparam int IDX_W     = (MAX_LEVEL > 1) ? $clog2(MAX_LEVEL) : 1;
	localparam int POS_W     = 4;
	localparam int LEVEL_W   = 4;
	localparam int LEN_W     = 9;
	localparam int DELTA_W   = 10;
	localparam int CFG_IDX_W = 1;

	localparam logic [LEVEL_W-1:0]   LEVEL_RST = LEVEL_W'(5);
	localparam logic [LEN_W-1:0]     LEN_RST   = LEN_W'(16);
	localparam logic [CFG_IDX_W-1:0] CFG_CURVE_LEVEL = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH = CFG_IDX_W'(1);

	localparam logic RULE_X = 1'b0;
	localparam logic RULE_Y = 1'b1;

	typedef enum logic [2:0] {
		SYM_PLUS  = 3'd0,
		SYM_MINUS = 3'd1,
		SYM_X     = 3'd2,
		SYM_Y     = 3'd3,
		SYM_F     = 3'd4
	} sym_t;

	typedef struct packed {
		logic             kind;
		logic [POS_W-1:0] pos;
	} frame_t;

	typedef struct packed {
		logic restart;
		logic step;
	} walk_cmd_t;

	typedef struct packed {
		logic       empty;
		logic       found;
		logic [1:0] heading;
	} walk_stat_t;

	typedef struct packed {
		logic       seg;
		logic       fin;
		logic [1:0] heading;
	} seg_info_t;

	// X -> +YF-XFX-FY+   Y -> -XF+YFY+FX-
	function automatic sym_t rule_sym(input logic kind, input logic [POS_W-1:0] pos);
		sym_t s;
		case (pos)
			POS_W'(0):  s = kind ? SYM_MINUS : SYM_PLUS;
			POS_W'(1):  s = kind ? SYM_X     : SYM_Y;
			POS_W'(2):  s = SYM_F;
			POS_W'(3):  s = kind ? SYM_PLUS  : SYM_MINUS;
			POS_W'(4):  s = kind ? SYM_Y     : SYM_X;
			POS_W'(5):  s = SYM_F;
			POS_W'(6):  s = kind ? SYM_Y     : SYM_X;
			POS_W'(7):  s = kind ? SYM_PLUS  : SYM_MINUS;
			POS_W'(8):  s = SYM_F;
			POS_W'(9):  s = kind ? SYM_X     : SYM_Y;
			POS_W'(10): s = kind ? SYM_MINUS : SYM_PLUS;
			default:    s = SYM_F;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

/* src/hcsg_walker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hcsg_walker
// Expansion stack and turtle heading; walks one grammar symbol or one frame
// pop per step.
// ----------------------------------------------------------------------------
module hcsg_walker (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire hcsg_pkg::walk_cmd_t        cmd,
	input  wire [hcsg_pkg::LEVEL_W-1:0]     level,
	output hcsg_pkg::walk_stat_t            stat
);
	import hcsg_pkg::*;

	frame_t             stack_q [MAX_LEVEL];
	logic [DEPTH_W-1:0] depth_q;
	logic [1:0]         heading_q;

	logic [DEPTH_W-1:0] lvl_eff;
	logic [DEPTH_W-1:0] depth_m1;
	logic [IDX_W-1:0]   idx;
	logic [IDX_W-1:0]   push_idx;
	frame_t             top;
	sym_t               sym;
	logic               empty;
	logic               pos_end;
	logic               can_push;
	logic               do_step;

	always_comb begin
		lvl_eff  = (32'(level) > MAX_LEVEL) ? DEPTH_W'(MAX_LEVEL) : DEPTH_W'(level);
		depth_m1 = depth_q - DEPTH_W'(1);
		idx      = depth_m1[IDX_W-1:0];
		push_idx = depth_q[IDX_W-1:0];
		top      = stack_q[idx];
		sym      = rule_sym(top.kind, top.pos);
		empty    = (depth_q == '0);
		pos_end  = (32'(top.pos) >= RULE_LEN);
		can_push = (depth_q < lvl_eff);
		do_step  = cmd.step && !empty;
	end

	assign stat.empty   = empty;
	assign stat.found   = !empty && !pos_end && (sym == SYM_F);
	assign stat.heading = heading_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= '0;
			heading_q <= '0;
		end else if (cmd.restart) begin
			depth_q   <= (lvl_eff != '0) ? DEPTH_W'(1) : '0;
			heading_q <= '0;
		end else if (do_step) begin
			if (pos_end) begin
				depth_q <= depth_m1;
			end else begin
				case (sym)
					SYM_PLUS:  heading_q <= heading_q + 2'd1;
					SYM_MINUS: heading_q <= heading_q - 2'd1;
					SYM_X, SYM_Y: begin
						if (can_push)
							depth_q <= depth_q + DEPTH_W'(1);
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.restart) begin
			stack_q[0] <= '{kind: RULE_X, pos: '0};
		end else if (do_step && !pos_end) begin
			stack_q[idx].pos <= top.pos + POS_W'(1);
			if ((sym == SYM_X || sym == SYM_Y) && can_push)
				stack_q[push_idx] <= '{kind: (sym == SYM_Y) ? RULE_Y : RULE_X, pos: '0};
		end
	end

endmodule
`default_nettype wire

/* src/hcsg_seg_fmt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hcsg_seg_fmt
// Output register: scales the heading unit vector by the step length and
// holds the segment until the request is taken.
// ----------------------------------------------------------------------------
module hcsg_seg_fmt (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                load,
	input  wire hcsg_pkg::seg_info_t           info,
	input  wire [hcsg_pkg::LEN_W-1:0]          step_len,
	output logic                               free,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic                               seg_valid,
	output logic [1:0]                         heading,
	output logic signed [hcsg_pkg::DELTA_W-1:0] delta_x,
	output logic signed [hcsg_pkg::DELTA_W-1:0] delta_y,
	output logic                               final_segment
);
	import hcsg_pkg::*;

	logic signed [DELTA_W-1:0] pos_len;
	logic signed [DELTA_W-1:0] neg_len;
	logic signed [DELTA_W-1:0] dx;
	logic signed [DELTA_W-1:0] dy;

	always_comb begin
		pos_len = $signed(DELTA_W'(step_len));
		neg_len = -pos_len;
		dx = '0;
		dy = '0;
		if (info.seg) begin
			case (info.heading)
				2'd0:    dx = pos_len;
				2'd1:    dy = neg_len;
				2'd2:    dx = neg_len;
				2'd3:    dy = pos_len;
				default: ;
			endcase
		end
	end

	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			seg_valid     <= info.seg;
			heading       <= info.seg ? info.heading : 2'd0;
			delta_x       <= dx;
			delta_y       <= dy;
			final_segment <= info.seg && info.fin;
		end
	end

endmodule
`default_nettype wire

/* src/hilbert_curve_step_generator.sv */
`default_nettype none
// Request: the walker takes steps (symbols and frame pops,
//   one per cycle) up to and including the next F, or the pops to an empty
//   stack, then emits the segment; the stack is L frames deep (L <= 8).
//   A restart first adds the steps to the first F.
// Throughput: one request at a time; ready only while idle.
// Reset: no curve active, heading 0, curve_level 5, step_length 16.
// ----------------------------------------------------------------------------
// hilbert_curve_step_generator
// Hilbert curve L-system turtle: one segment (or an empty result once the curve is done) per request.
// ----------------------------------------------------------------------------
module hilbert_curve_step_generator (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [hcsg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [hcsg_pkg::LEN_W-1:0]           cfg_wdata,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire                                 restart,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic                                seg_valid,
	output logic [1:0]                          heading,
	output logic signed [hcsg_pkg::DELTA_W-1:0] delta_x,
	output logic signed [hcsg_pkg::DELTA_W-1:0] delta_y,
	output logic                                final_segment
);
	import hcsg_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_WALK_A = 4'b0010,
		ST_WALK_B = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t             state_q;
	logic [LEVEL_W-1:0] level_q;
	logic [LEN_W-1:0]   step_len_q;
	logic               done_q;
	seg_info_t          info_q;

	walk_cmd_t  cmd;
	walk_stat_t stat;
	logic       accept;
	logic       free;
	logic       load;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign cmd.restart = accept && restart;
	assign cmd.step    = (state_q == ST_WALK_A) || (state_q == ST_WALK_B);
	assign load        = (state_q == ST_EMIT) && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= LEVEL_RST;
			step_len_q <= LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CURVE_LEVEL: level_q    <= cfg_wdata[LEVEL_W-1:0];
				CFG_STEP_LENGTH: step_len_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b1;
			info_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (restart) begin
							state_q <= ST_WALK_A;
						end else if (done_q) begin
							info_q  <= '0;
							state_q <= ST_EMIT;
						end else begin
							info_q.heading <= stat.heading;
							state_q        <= ST_WALK_B;
						end
					end
				end
				ST_WALK_A: begin
					if (stat.found) begin
						info_q.heading <= stat.heading;
						state_q        <= ST_WALK_B;
					end else if (stat.empty) begin
						done_q  <= 1'b1;
						info_q  <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_WALK_B: begin
					if (stat.found || stat.empty) begin
						done_q     <= stat.empty;
						info_q.seg <= 1'b1;
						info_q.fin <= stat.empty;
						state_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	hcsg_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.level  (level_q),
		.stat   (stat)
	);

	hcsg_seg_fmt u_fmt (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.info          (info_q),
		.step_len      (step_len_q),
		.free          (free),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.seg_valid     (seg_valid),
		.heading       (heading),
		.delta_x       (delta_x),
		.delta_y       (delta_y),
		.final_segment (final_segment)
	);

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request accepted but block still ready");

	a_final_is_seg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_segment |-> seg_valid)
		else $error("final flag without segment");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !seg_valid |-> heading == 2'd0 && delta_x == '0 && delta_y == '0)
		else $error("empty result with nonzero fields");

	a_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !heading[0] |-> delta_y == '0)
		else $error("x heading with y displacement");

endmodule
`default_nettype wire
